FILE: rtl/per_client_fixed_window_limiter_defines.svh
// assertion macros for the per-client fixed-window limiter
`ifndef PER_CLIENT_FIXED_WINDOW_LIMITER_DEFINES_SVH
`define PER_CLIENT_FIXED_WINDOW_LIMITER_DEFINES_SVH

// property checked on every clock edge outside reset
`define PCFWL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define PCFWL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pcfwl_pkg.sv
// shared types and constants of the per-client fixed-window limiter
`timescale 1ns / 1ps
`default_nettype none
package pcfwl_pkg;

  localparam int SLOT_W       = 6;
  localparam int TIME_BITS    = 32;
  localparam int NOW_W        = 32;
  localparam int LIMIT_W      = 16;
  localparam int DUR_W        = 24;
  localparam int MODE_W       = 3;
  localparam int TBL_AW       = SLOT_W + 1;
  localparam int TBL_DEPTH    = 2 ** TBL_AW;

  localparam int IN_DATA_W    = 64;
  localparam int IN_USER_W    = MODE_W;
  localparam int OUT_DATA_W   = 8;

  localparam int APB_AW       = 5;
  localparam int APB_DW       = 32;

  // register indexes
  localparam logic [2:0] REG_REQUEST_LIMIT    = 3'd0;
  localparam logic [2:0] REG_MESSAGE_LIMIT    = 3'd1;
  localparam logic [2:0] REG_CONNECTION_LIMIT = 3'd2;
  localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd3;
  localparam logic [2:0] REG_BLOCK_CEILING    = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_REQUEST     = 3'd0,
    MODE_MESSAGE     = 3'd1,
    MODE_CONNECTION  = 3'd2,
    MODE_BLOCK       = 3'd3,
    MODE_UNBLOCK     = 3'd4,
    MODE_QUERY       = 3'd5,
    MODE_RESET_COUNT = 3'd6
  } mode_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] request_limit;
    logic [LIMIT_W-1:0] message_limit;
    logic [LIMIT_W-1:0] connection_limit;
    logic [LIMIT_W-1:0] window_length;
    logic [DUR_W-1:0]   block_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]   count;
    logic [TIME_BITS-1:0] win_start;
    logic                 flag;
    logic [TIME_BITS-1:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

FILE: rtl/pcfwl_cfg.sv
// apb configuration registers of the limiter
`timescale 1ns / 1ps
`default_nettype none
module pcfwl_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcfwl_pkg::APB_AW-1:0] paddr,
  input  wire logic [pcfwl_pkg::APB_DW-1:0] pwdata,
  output logic      [pcfwl_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output pcfwl_pkg::cfg_t                 cfg_o
);
  import pcfwl_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_REQUEST_LIMIT:    cfg_d.request_limit    = pwdata[LIMIT_W-1:0];
        REG_MESSAGE_LIMIT:    cfg_d.message_limit    = pwdata[LIMIT_W-1:0];
        REG_CONNECTION_LIMIT: cfg_d.connection_limit = pwdata[LIMIT_W-1:0];
        REG_WINDOW_LENGTH:    cfg_d.window_length    = pwdata[LIMIT_W-1:0];
        REG_BLOCK_CEILING:    cfg_d.block_ceiling    = pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REQUEST_LIMIT:    prdata = APB_DW'(cfg_q.request_limit);
      REG_MESSAGE_LIMIT:    prdata = APB_DW'(cfg_q.message_limit);
      REG_CONNECTION_LIMIT: prdata = APB_DW'(cfg_q.connection_limit);
      REG_WINDOW_LENGTH:    prdata = APB_DW'(cfg_q.window_length);
      REG_BLOCK_CEILING:    prdata = APB_DW'(cfg_q.block_ceiling);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_limit    <= LIMIT_W'(60);
      cfg_q.message_limit    <= LIMIT_W'(60);
      cfg_q.connection_limit <= LIMIT_W'(10);
      cfg_q.window_length    <= LIMIT_W'(60);
      cfg_q.block_ceiling    <= DUR_W'(3600);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/pcfwl_table.sv
// entry memory for both tables with per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none
module pcfwl_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [pcfwl_pkg::TBL_AW-1:0]  rd_addr_i,
  output pcfwl_pkg::entry_t                  rd_entry_o,
  input  wire logic                          wr_en_i,
  input  wire logic [pcfwl_pkg::TBL_AW-1:0]  wr_addr_i,
  input  wire pcfwl_pkg::entry_t             wr_entry_i
);
  import pcfwl_pkg::*;

  entry_t               mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] valid_q;
  entry_t               rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-written entries read as zero
  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

FILE: rtl/pcfwl_update.sv
// entry update for checks, block, unblock, query and count-reset commands
`timescale 1ns / 1ps
`default_nettype none
module pcfwl_update (
  input  wire logic [pcfwl_pkg::MODE_W-1:0] mode_i,
  input  wire logic [pcfwl_pkg::NOW_W-1:0]  now_i,
  input  wire logic [pcfwl_pkg::DUR_W-1:0]  req_i,
  input  wire pcfwl_pkg::cfg_t              cfg_i,
  input  wire pcfwl_pkg::entry_t            entry_i,
  output pcfwl_pkg::entry_t                 entry_o,
  output logic                              we_o,
  output logic                              allowed_o,
  output logic                              blocked_o
);
  import pcfwl_pkg::*;

  logic [TIME_BITS-1:0] now;
  logic                 expired;
  logic [TIME_BITS-1:0] age;
  logic                 new_win;
  logic [LIMIT_W-1:0]   limit_sel;
  logic [LIMIT_W-1:0]   lim;
  logic [LIMIT_W-1:0]   cnt;
  logic [DUR_W-1:0]     dur;
  logic [TIME_BITS:0]   until_sum;
  logic [TIME_BITS-1:0] until_sat;
  logic                 is_check;

  assign now       = TIME_BITS'(now_i);
  assign expired   = entry_i.flag && (now >= entry_i.expiry);
  assign age       = now - entry_i.win_start;
  assign new_win   = (entry_i.win_start == '0) ||
                     (age >= TIME_BITS'(cfg_i.window_length));
  assign cnt       = new_win ? '0 : entry_i.count;
  assign lim       = (limit_sel == '0) ? LIMIT_W'(1) : limit_sel;
  assign dur       = (req_i < cfg_i.block_ceiling) ? req_i : cfg_i.block_ceiling;
  assign until_sum = {1'b0, now} + (TIME_BITS + 1)'(dur);
  assign until_sat = until_sum[TIME_BITS] ? '1 : until_sum[TIME_BITS-1:0];
  assign is_check  = (mode_i == MODE_REQUEST) || (mode_i == MODE_MESSAGE) ||
                     (mode_i == MODE_CONNECTION);

  always_comb begin
    unique case (mode_i)
      MODE_MESSAGE:    limit_sel = cfg_i.message_limit;
      MODE_CONNECTION: limit_sel = cfg_i.connection_limit;
      default:         limit_sel = cfg_i.request_limit;
    endcase
  end

  always_comb begin
    entry_o   = entry_i;
    we_o      = 1'b1;
    allowed_o = 1'b0;
    unique case (mode_i)
      MODE_REQUEST, MODE_MESSAGE, MODE_CONNECTION, MODE_QUERY: begin
        if (expired) begin
          entry_o.flag   = 1'b0;
          entry_o.expiry = '0;
        end
        if (is_check && !(entry_i.flag && !expired)) begin
          entry_o.win_start = new_win ? now : entry_i.win_start;
          if (cnt >= lim) begin
            entry_o.count = cnt;
          end else begin
            entry_o.count = cnt + LIMIT_W'(1);
            allowed_o     = 1'b1;
          end
        end
      end
      MODE_BLOCK: begin
        entry_o.flag   = 1'b1;
        entry_o.expiry = until_sat;
      end
      MODE_UNBLOCK: begin
        entry_o.flag   = 1'b0;
        entry_o.expiry = '0;
      end
      MODE_RESET_COUNT: begin
        entry_o.count     = '0;
        entry_o.win_start = '0;
      end
      default: begin
        we_o = 1'b0;
      end
    endcase
  end

  assign blocked_o = entry_o.flag;

endmodule
`default_nettype wire

FILE: rtl/per_client_fixed_window_limiter.sv
// top level of the per-client fixed-window limiter
//
//  port group  dir  fields (low bit first)
//  s_axis      in   tuser: mode[2:0]; tdata: slot[5:0], now_seconds[37:6],
//                   block_seconds[61:38]
//  m_axis      out  tdata: allowed[0], blocked[1]
//  apb         in   registers at 4*i: request_limit, message_limit,
//                   connection_limit, window_length, block_ceiling
//
//  an item is handled as one entry read from the table memory, then update
//  and write-back of that entry in the update state
//  a stalled m_axis holds the item in the update state until the output frees
//  reset clears the entry valid bits at once; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "per_client_fixed_window_limiter_defines.svh"
module per_client_fixed_window_limiter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // slot, now_seconds, block_seconds
  input  wire logic [pcfwl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  wire logic [pcfwl_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // allowed, blocked
  output logic      [pcfwl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pcfwl_pkg::APB_AW-1:0]      paddr,
  input  wire logic [pcfwl_pkg::APB_DW-1:0]      pwdata,
  output logic      [pcfwl_pkg::APB_DW-1:0]      prdata,
  output logic                                   pready
);
  import pcfwl_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_e;

  state_e              state_q, state_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [TBL_AW-1:0]   addr_q, addr_d;
  logic [NOW_W-1:0]    now_q, now_d;
  logic [DUR_W-1:0]    req_q, req_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_data_q, out_data_d;

  cfg_t                cfg;
  entry_t              rd_entry;
  entry_t              wr_entry;
  logic                upd_we;
  logic                allowed;
  logic                blocked;
  logic                accept;
  logic                out_free;
  logic                tbl_we;
  logic [TBL_AW-1:0]   rd_addr;
  logic [MODE_W-1:0]   s_mode;

  assign s_mode        = s_axis_tuser[MODE_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_addr       = {s_mode == MODE_CONNECTION, s_axis_tdata[SLOT_W-1:0]};
  assign out_free      = !out_valid_q || m_axis_tready;
  assign tbl_we        = (state_q == ST_MODIFY) && out_free && upd_we;

  pcfwl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcfwl_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (tbl_we),
    .wr_addr_i  (addr_q),
    .wr_entry_i (wr_entry)
  );

  pcfwl_update u_update (
    .mode_i    (mode_q),
    .now_i     (now_q),
    .req_i     (req_q),
    .cfg_i     (cfg),
    .entry_i   (rd_entry),
    .entry_o   (wr_entry),
    .we_o      (upd_we),
    .allowed_o (allowed),
    .blocked_o (blocked)
  );

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    now_d       = now_q;
    req_d       = req_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d  = s_mode;
          addr_d  = rd_addr;
          now_d   = s_axis_tdata[SLOT_W +: NOW_W];
          req_d   = s_axis_tdata[SLOT_W + NOW_W +: DUR_W];
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {blocked, allowed};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= '0;
      addr_q      <= '0;
      now_q       <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      addr_q      <= addr_d;
      now_q       <= now_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_data_q);

  `PCFWL_ASSERT_NEXT(a_accept_to_modify, accept, state_q == ST_MODIFY, "accept did not start update")
  `PCFWL_ASSERT(a_write_in_modify, !tbl_we || (state_q == ST_MODIFY), "table write outside update")
  `PCFWL_ASSERT(a_no_write_on_stall, !((state_q == ST_MODIFY) && out_valid_q && !m_axis_tready) || !tbl_we, "write-back while output stalled")
  `PCFWL_ASSERT_NEXT(a_result_held, out_valid_q && !m_axis_tready, out_valid_q && $stable(out_data_q), "stalled result changed")

endmodule
`default_nettype wire
